// File: src/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    localparam logic [7:0]  LEAD_TWO    = 8'hC0;
    localparam logic [7:0]  LEAD_THREE  = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR   = 8'hF0;
    localparam logic [7:0]  LEAD_BAD    = 8'hF8;
    localparam logic [7:0]  ASCII_LIMIT = 8'h80;
    localparam logic [5:0]  CONT_MASK   = 6'h3F;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
    localparam logic [4:0]  SURR_TOP5   = 5'b11011;
    localparam logic [4:0]  PLANE_MAX   = 5'h10;

    localparam logic [1:0]  UNITS_NONE  = 2'd0;
    localparam logic [1:0]  UNITS_ONE   = 2'd1;
    localparam logic [1:0]  UNITS_PAIR  = 2'd2;

    typedef struct packed {
        logic [1:0]  units;
        logic [15:0] first_unit;
        logic [15:0] second_unit;
    } t_units;

    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] partial;
    } t_seq_state;

endpackage

`default_nettype wire

// File: src/u8u16_byte_if.sv
// ----------------------------------------------------------------------------
// u8u16_byte_if
// Valid/ready channel carrying one UTF-8 byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: src/u8u16_unit_if.sv
// ----------------------------------------------------------------------------
// u8u16_unit_if
// Valid/ready channel carrying one UTF-16 code unit per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_of_run;

    modport source (output valid, output code_unit, output last_of_run, input ready);
    modport sink   (input valid, input code_unit, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: src/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// Byte decode: next sequence state and the code units a byte completes.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode (
    input  wire logic [7:0]             i_data_byte,
    input  wire u8u16_pkg::t_seq_state  i_state,
    output u8u16_pkg::t_seq_state       o_state,
    output u8u16_pkg::t_units           o_units
);

    logic [20:0] code_point;
    logic [19:0] offset;
    logic [1:0]  pend_dec;

    assign code_point = {i_state.partial[14:0], i_data_byte[5:0] & u8u16_pkg::CONT_MASK};
    assign offset     = code_point[19:0] - 20'h10000;
    assign pend_dec   = i_state.pending - 2'd1;

    always_comb begin
        o_state             = i_state;
        o_units.units       = u8u16_pkg::UNITS_NONE;
        o_units.first_unit  = code_point[15:0];
        o_units.second_unit = {u8u16_pkg::LO_SURR_TAG, offset[9:0]};

        if (i_state.pending != 2'd0) begin
            o_state.partial = code_point;
            o_state.pending = pend_dec;
            if (pend_dec == 2'd0) begin
                if (code_point[20:16] == 5'd0) begin
                    if (code_point[15:11] != u8u16_pkg::SURR_TOP5) begin
                        o_units.units = u8u16_pkg::UNITS_ONE;
                    end
                end else if (code_point[20:16] <= u8u16_pkg::PLANE_MAX) begin
                    o_units.units      = u8u16_pkg::UNITS_PAIR;
                    o_units.first_unit = {u8u16_pkg::HI_SURR_TAG, offset[19:10]};
                end
            end
        end else if (i_data_byte < u8u16_pkg::ASCII_LIMIT) begin
            o_units.units      = u8u16_pkg::UNITS_ONE;
            o_units.first_unit = {8'd0, i_data_byte};
        end else if (i_data_byte < u8u16_pkg::LEAD_TWO) begin
            o_state = i_state;
        end else if (i_data_byte < u8u16_pkg::LEAD_THREE) begin
            o_state.partial = {16'd0, i_data_byte[4:0]};
            o_state.pending = 2'd1;
        end else if (i_data_byte < u8u16_pkg::LEAD_FOUR) begin
            o_state.partial = {17'd0, i_data_byte[3:0]};
            o_state.pending = 2'd2;
        end else if (i_data_byte < u8u16_pkg::LEAD_BAD) begin
            o_state.partial = {18'd0, i_data_byte[2:0]};
            o_state.pending = 2'd3;
        end
    end

endmodule

`default_nettype wire

// File: src/utf8_to_utf16_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder
// UTF-8 byte stream in, UTF-16 code unit stream out.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, except while the output holds an untaken unit
// or a high surrogate. A byte that completes a BMP character, or an ASCII
// byte, gives one code unit in the cycle after it is taken; a supplementary
// character gives a high then a low surrogate, held as a pair by the output
// register. Bytes that give no unit (lead bytes, continuation bytes not yet
// closing a sequence, stray or invalid bytes, dropped values) are still
// taken. last_of_run marks the final unit of each character. Continuation
// bytes are not checked; surrogate values and values above 10FFFF are dropped.
`default_nettype none

module utf8_to_utf16_stream_decoder (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    u8u16_byte_if.sink    i_byte,
    u8u16_unit_if.source  o_unit
);

    u8u16_pkg::t_seq_state r_state;
    u8u16_pkg::t_seq_state n_state;
    u8u16_pkg::t_units     dec_units;

    logic        r_valid;
    logic        r_second;
    logic [15:0] r_unit;
    logic        r_last;
    logic [15:0] r_second_unit;
    logic        in_take;
    logic        out_take;

    u8u16_decode u_decode (
        .i_data_byte (i_byte.data_byte),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_units     (dec_units)
    );

    assign i_byte.ready       = !r_valid || (o_unit.ready && !r_second);
    assign in_take            = i_byte.valid && i_byte.ready;
    assign out_take           = r_valid && o_unit.ready;
    assign o_unit.valid       = r_valid;
    assign o_unit.code_unit   = r_unit;
    assign o_unit.last_of_run = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (in_take) begin
                r_state <= n_state;
                case (dec_units.units)
                    u8u16_pkg::UNITS_ONE: begin
                        r_valid  <= 1'b1;
                        r_unit   <= dec_units.first_unit;
                        r_last   <= 1'b1;
                        r_second <= 1'b0;
                    end
                    u8u16_pkg::UNITS_PAIR: begin
                        r_valid       <= 1'b1;
                        r_unit        <= dec_units.first_unit;
                        r_last        <= 1'b0;
                        r_second      <= 1'b1;
                        r_second_unit <= dec_units.second_unit;
                    end
                    default: begin
                        r_valid  <= 1'b0;
                        r_second <= 1'b0;
                    end
                endcase
            end else if (out_take) begin
                if (r_second) begin
                    r_unit   <= r_second_unit;
                    r_last   <= 1'b1;
                    r_second <= 1'b0;
                end else begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 to UTF-16 stream decoder. Directed byte
// sequences cover the single-byte classes, BMP and supplementary characters,
// dropped values and unchecked continuation words. Random sequences follow,
// run under several sender idle and receiver stall mixes. An in-bench decoder
// predicts every code unit, and each result word is checked in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [20:0] SUPP_BASE      = 21'h10000;
    localparam logic [20:0] UNICODE_MAX    = 21'h10FFFF;
    localparam logic [7:0]  SURR_LEAD      = 8'hED;
    localparam logic [7:0]  SURR_CONT      = 8'hA0;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          REPORT_LIMIT   = 10;
    localparam int          RANDOM_PER_RUN = 382;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
    } t_code_unit;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8u16_byte_if byte_ch();
    u8u16_unit_if unit_ch();

    utf8_to_utf16_stream_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_unit  (unit_ch)
    );

    t_code_unit  expected_units[$];
    logic [1:0]  seq_pending;
    logic [20:0] seq_point;

    int idle_pct;
    int stall_pct;
    int bytes_sent;
    int bytes_decoded;
    int units_checked;
    int pairs_predicted;
    int values_dropped;
    int mismatches;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        unit_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_unit(input logic [15:0] unit, input logic last);
        t_code_unit u;
        u.code_unit   = unit;
        u.last_of_run = last;
        expected_units.push_back(u);
    endtask

    task automatic emit_code_point(input logic [20:0] cp);
        logic [19:0] v;
        if (cp < SUPP_BASE) begin
            if (cp[15:11] == u8u16_pkg::SURR_TOP5) begin
                values_dropped++;
            end else begin
                push_unit(cp[15:0], 1'b1);
            end
        end else if (cp > UNICODE_MAX) begin
            values_dropped++;
        end else begin
            v = 20'(cp - SUPP_BASE);
            push_unit({u8u16_pkg::HI_SURR_TAG, v[19:10]}, 1'b0);
            push_unit({u8u16_pkg::LO_SURR_TAG, v[9:0]}, 1'b1);
            pairs_predicted++;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, output bit taken);
        taken = 1'b1;
        if (seq_pending != 2'd0) begin
            seq_point   = {seq_point[14:0], b[5:0]};
            seq_pending = seq_pending - 2'd1;
            if (seq_pending == 2'd0) begin
                emit_code_point(seq_point);
            end
        end else if (b < u8u16_pkg::ASCII_LIMIT) begin
            push_unit({8'h00, b}, 1'b1);
        end else if (b < u8u16_pkg::LEAD_TWO) begin
            taken = 1'b0;
        end else if (b < u8u16_pkg::LEAD_THREE) begin
            seq_point   = {16'd0, b[4:0]};
            seq_pending = 2'd1;
        end else if (b < u8u16_pkg::LEAD_FOUR) begin
            seq_point   = {17'd0, b[3:0]};
            seq_pending = 2'd2;
        end else if (b < u8u16_pkg::LEAD_BAD) begin
            seq_point   = {18'd0, b[2:0]};
            seq_pending = 2'd3;
        end else begin
            taken = 1'b0;
        end
    endtask

    task automatic note_failure(input string what, input t_code_unit want,
                                input logic [15:0] got_unit, input logic got_last);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected unit %h last %b, got unit %h last %b",
                     $realtime, what, want.code_unit, want.last_of_run, got_unit, got_last);
        end
    endtask

    always @(posedge i_clk) begin : unit_checker
        t_code_unit want;
        if (i_rst_n && unit_ch.valid && unit_ch.ready) begin
            if (expected_units.size() == 0) begin
                want = '0;
                note_failure("unexpected word", want, unit_ch.code_unit, unit_ch.last_of_run);
            end else begin
                want = expected_units.pop_front();
                units_checked++;
                if (unit_ch.code_unit !== want.code_unit ||
                    unit_ch.last_of_run !== want.last_of_run) begin
                    note_failure("mismatch", want, unit_ch.code_unit, unit_ch.last_of_run);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        decode_byte(b, taken);
        bytes_sent++;
        if (taken) begin
            bytes_decoded++;
        end
    endtask

    task automatic drain_units();
        byte_ch.valid <= 1'b0;
        while (expected_units.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'(u8u16_pkg::ASCII_LIMIT | $urandom_range(63));
    endfunction

    task automatic test_single_bytes();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hBF);
        send_byte(8'hF8);
        send_byte(8'hFF);
    endtask

    task automatic test_bmp_sequences();
        send_byte(8'hC0); send_byte(8'h80);
        send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
        send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
    endtask

    task automatic test_supplementary();
        send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
        send_byte(8'hF4); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
    endtask

    task automatic test_unchecked_continuation();
        send_byte(8'hC3);
        send_byte(8'h41);
    endtask

    task automatic send_random_sequence();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 20) begin
            send_byte(8'($urandom_range(8'h7F)));
        end else if (kind < 40) begin
            send_byte(8'(u8u16_pkg::LEAD_TWO | $urandom_range(31)));
            send_byte(cont_byte());
        end else if (kind < 62) begin
            if ($urandom_range(3) == 0) begin
                send_byte(SURR_LEAD);
                send_byte(8'(SURR_CONT | $urandom_range(31)));
            end else begin
                send_byte(8'(u8u16_pkg::LEAD_THREE | $urandom_range(15)));
                send_byte(cont_byte());
            end
            send_byte(cont_byte());
        end else if (kind < 85) begin
            if ($urandom_range(3) != 0) begin
                send_byte(8'(u8u16_pkg::LEAD_FOUR | $urandom_range(4)));
            end else begin
                send_byte(8'(u8u16_pkg::LEAD_FOUR | $urandom_range(7)));
            end
            repeat (3) send_byte(cont_byte());
        end else if (kind < 93) begin
            if ($urandom_range(1) == 0) begin
                send_byte(cont_byte());
            end else begin
                send_byte(8'(u8u16_pkg::LEAD_BAD | $urandom_range(7)));
            end
        end else begin
            send_byte(8'($urandom_range(8'hF7, 8'hC0)));
            n = $urandom_range(3, 1);
            repeat (n) send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_stream(input int idle, input int stall, input int count);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = bytes_decoded + count;
        while (bytes_decoded < target) begin
            send_random_sequence();
        end
        drain_units();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        unit_ch.ready     = 1'b0;
        seq_pending       = 2'd0;
        seq_point         = '0;
        idle_pct          = 0;
        stall_pct         = 0;
        bytes_sent        = 0;
        bytes_decoded     = 0;
        units_checked     = 0;
        pairs_predicted   = 0;
        values_dropped    = 0;
        mismatches        = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_bytes();
        test_bmp_sequences();
        test_supplementary();
        test_unchecked_continuation();
        drain_units();

        test_random_stream(0, 0, RANDOM_PER_RUN);
        test_random_stream(48, 0, RANDOM_PER_RUN);
        test_random_stream(0, 48, RANDOM_PER_RUN);
        test_random_stream(20, 20, RANDOM_PER_RUN);

        $display("Covered %0d bytes (%0d decoded) under four idle/stall mixes.",
                 bytes_sent, bytes_decoded);
        $display("Checked %0d code units, %0d surrogate pairs, %0d values dropped.",
                 units_checked, pairs_predicted, values_dropped);
        if (mismatches == 0 && expected_units.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d failures, %0d words still expected", mismatches,
                     expected_units.size());
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d words still expected", expected_units.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
